### design/sstp_pkg.sv
package sstp_pkg;

    localparam int DEB_W  = 8;
    localparam int COOL_W = 12;
    localparam int HOLD_W = 10;
    localparam int AGE_W  = 9;
    localparam int CAGE_W = 13;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;

    localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};
    localparam logic [CAGE_W-1:0] CAGE_MAX = {CAGE_W{1'b1}};

    localparam logic [DEB_W-1:0]  DEB_RST  = 8'd25;
    localparam logic [COOL_W-1:0] COOL_RST = 12'd250;
    localparam logic [HOLD_W-1:0] HOLD_RST = 10'd80;

    localparam logic [IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_COOLDOWN = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HOLD     = 2'd2;

    typedef enum logic [1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_LEFT    = 2'd1,
        DIR_RIGHT   = 2'd2
    } t_dir;

    typedef struct packed {
        logic stable_next;
        logic press;
    } t_deb_status;

endpackage

### design/sstp_debounce.sv
module sstp_debounce (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_raw,
    input  logic [sstp_pkg::DEB_W-1:0] i_debounce_ticks,
    output sstp_pkg::t_deb_status     o_status
);
    import sstp_pkg::*;

    logic             r_stable;
    logic             r_last;
    logic [AGE_W-1:0] r_age;
    logic             n_stable;
    logic [AGE_W-1:0] n_age;
    logic             press;

    always_comb begin
        if (i_raw != r_last) begin
            n_age = '0;
        end else if (r_age < AGE_MAX) begin
            n_age = r_age + AGE_W'(1);
        end else begin
            n_age = r_age;
        end
        n_stable = r_stable;
        press    = 1'b0;
        if (n_age > AGE_W'(i_debounce_ticks) && i_raw != r_stable) begin
            n_stable = i_raw;
            press    = ~i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_last   <= 1'b1;
            r_age    <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_last   <= i_raw;
            r_age    <= n_age;
        end
    end

    assign o_status.stable_next = n_stable;
    assign o_status.press       = press;

endmodule

### design/sstp_tap.sv
module sstp_tap (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_tap,
    input  logic [sstp_pkg::HOLD_W-1:0] i_hold_ticks,
    output logic                       o_active
);
    import sstp_pkg::*;

    logic [HOLD_W-1:0] r_remain;
    logic [HOLD_W-1:0] n_remain;

    always_comb begin
        if (i_tap) begin
            n_remain = i_hold_ticks;
        end else if (r_remain != '0) begin
            n_remain = r_remain - HOLD_W'(1);
        end else begin
            n_remain = r_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
        end else if (i_en) begin
            r_remain <= n_remain;
        end
    end

    assign o_active = (n_remain != '0);

endmodule

### design/stalk_switch_to_tap_pulses_core.sv
// channel | signals                                              | transfer when
// --------+------------------------------------------------------+------------------------
// in      | i_left_raw, i_right_raw, i_beam_raw                  | i_in_valid & o_in_ready
// out     | o_left_button, o_right_button, o_beam_button,        | o_out_valid & i_out_ready
//         | o_direction_now                                      |
// cfg     | i_cfg_we, i_cfg_index, i_cfg_data                    | i_cfg_we
//
// one tick per cycle unless stalled: each transfer updates state and loads the result
// result appears in the cycle after its input transfer
// o_in_ready is high while the result register is empty or is being emptied
// a stall on the output holds the result and all switch state
// synchronous reset restores the register defaults and the released switch state
module stalk_switch_to_tap_pulses_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_left_raw,
    input  logic                        i_right_raw,
    input  logic                        i_beam_raw,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_left_button,
    output logic                        o_right_button,
    output logic                        o_beam_button,
    output logic [1:0]                  o_direction_now,
    input  logic                        i_cfg_we,
    input  logic [sstp_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [sstp_pkg::CFG_W-1:0]  i_cfg_data
);
    import sstp_pkg::*;

    logic [DEB_W-1:0]  r_deb_ticks;
    logic [COOL_W-1:0] r_cool_ticks;
    logic [HOLD_W-1:0] r_hold_ticks;

    t_dir              r_dir;
    t_dir              n_dir;
    logic [CAGE_W-1:0] r_cool;
    logic [CAGE_W-1:0] n_cool;
    logic              r_beam_last;
    logic              n_beam;

    logic              r_out_valid;
    logic              r_left_btn;
    logic              r_right_btn;
    logic              r_beam_btn;
    logic [1:0]        r_dir_out;

    logic              in_acc;
    t_deb_status       left_st;
    t_deb_status       right_st;
    logic              tap_left;
    logic              tap_right;
    logic              tap_beam;
    logic              left_act;
    logic              right_act;
    logic              beam_act;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_acc     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks  <= DEB_RST;
            r_cool_ticks <= COOL_RST;
            r_hold_ticks <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_deb_ticks  <= i_cfg_data[DEB_W-1:0];
                CFG_COOLDOWN: r_cool_ticks <= i_cfg_data[COOL_W-1:0];
                CFG_HOLD:     r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    sstp_debounce u_deb_left (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_acc),
        .i_raw            (i_left_raw),
        .i_debounce_ticks (r_deb_ticks),
        .o_status         (left_st)
    );

    sstp_debounce u_deb_right (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_acc),
        .i_raw            (i_right_raw),
        .i_debounce_ticks (r_deb_ticks),
        .o_status         (right_st)
    );

    always_comb begin
        n_cool = (r_cool < CAGE_MAX) ? r_cool + CAGE_W'(1) : r_cool;
        n_dir     = r_dir;
        tap_left  = left_st.press;
        tap_right = right_st.press;
        if (left_st.press) begin
            n_dir = DIR_LEFT;
        end
        if (right_st.press) begin
            n_dir = DIR_RIGHT;
        end
        // return to neutral, with a tap on the held side, once both sides are released and cooldown has passed
        if (left_st.stable_next && right_st.stable_next && n_dir != DIR_NEUTRAL &&
            n_cool > CAGE_W'(r_cool_ticks)) begin
            if (n_dir == DIR_LEFT) begin
                tap_left = 1'b1;
            end else begin
                tap_right = 1'b1;
            end
            n_dir  = DIR_NEUTRAL;
            n_cool = '0;
        end
        n_beam   = ~i_beam_raw;
        tap_beam = (n_beam != r_beam_last);
    end

    sstp_tap u_tap_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_acc),
        .i_tap        (tap_left),
        .i_hold_ticks (r_hold_ticks),
        .o_active     (left_act)
    );

    sstp_tap u_tap_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_acc),
        .i_tap        (tap_right),
        .i_hold_ticks (r_hold_ticks),
        .o_active     (right_act)
    );

    sstp_tap u_tap_beam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_acc),
        .i_tap        (tap_beam),
        .i_hold_ticks (r_hold_ticks),
        .o_active     (beam_act)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_NEUTRAL;
            r_cool      <= '0;
            r_beam_last <= 1'b0;
        end else if (in_acc) begin
            r_dir       <= n_dir;
            r_cool      <= n_cool;
            r_beam_last <= n_beam;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left_btn  <= left_act;
            r_right_btn <= right_act;
            r_beam_btn  <= beam_act;
            r_dir_out   <= n_dir;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_button   = r_left_btn;
    assign o_right_button  = r_right_btn;
    assign o_beam_button   = r_beam_btn;
    assign o_direction_now = r_dir_out;

    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("input transfer did not produce a result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_direction_now)
            && $stable(o_left_button) && $stable(o_right_button) && $stable(o_beam_button))
        else $error("stalled result changed");

    a_idle_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_dir) && $stable(r_cool) && $stable(r_beam_last))
        else $error("state changed without an input transfer");

    a_neutral_clears_cool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_dir != DIR_NEUTRAL && n_dir == DIR_NEUTRAL |=> r_cool == '0)
        else $error("cooldown not restarted on return to neutral");

endmodule
